// ===== design/least_loaded_sf_tracker_macros.svh =====
// assertion helpers for the spreading-factor tracker
`ifndef LEAST_LOADED_SF_TRACKER_MACROS_SVH
`define LEAST_LOADED_SF_TRACKER_MACROS_SVH

// plain property, checked on every clock outside reset
`define SFTRK_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication, checked outside reset
`define SFTRK_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/sftrk_pkg.sv =====
package sftrk_pkg;

    // table geometry
    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // entry layout: node id above, factor below
    localparam int ID_W    = 64;
    localparam int SF_W    = 4;
    localparam int ENTRY_W = ID_W + SF_W;

    // spreading factors 7..12
    localparam int SF_LOWEST = 7;
    localparam int SF_COUNT  = 6;
    localparam int SF_IDX_W  = $clog2(SF_COUNT);

    typedef enum logic [1:0] {
        MODE_REG    = 2'd0,
        MODE_UNREG  = 2'd1,
        MODE_ASSIGN = 2'd2
    } t_mode;

    // per-factor entry counts
    typedef logic [SF_COUNT-1:0][CNT_W-1:0] t_loads;

    // status from the least-load picker
    typedef struct packed {
        logic                done;
        logic [SF_IDX_W-1:0] best;
    } t_sel_stat;

    // factor is legal and inside the configured window
    function automatic logic sf_ok(input logic [7:0] sf, input logic [3:0] sf_min,
                                   input logic [3:0] sf_max);
        return (sf >= 8'(SF_LOWEST)) && (sf < 8'(SF_LOWEST + SF_COUNT)) &&
               (sf >= {4'b0000, sf_min}) && (sf <= {4'b0000, sf_max});
    endfunction

endpackage

// ===== design/least_loaded_sf_tracker.sv =====
// channel   valid        stall        payload
// input     i_in_valid   o_in_stall   i_mode, i_node_id, i_requested_sf
// output    o_out_valid  i_out_stall  o_accepted, o_assigned_sf, o_entry_count, o_load_sf*
// config    psel/penable pready (=1)  paddr, pwdata, prdata
//
// register and unregister scan the table and report; assign runs the picker first, then scans
// and appends; a bad factor or mode 3 goes straight to the report, as does an off-window pick
// the scan reads one entry per cycle from the entry ram
// the picker starts from factor 7 and makes five compares, one per cycle
// synchronous active-low reset empties the table; no clearing pass is needed
// a result waits in the output register while the next beat is taken and worked on
`include "least_loaded_sf_tracker_macros.svh"

module least_loaded_sf_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_node_id,
    input  logic [7:0]  i_requested_sf,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic [3:0]  o_assigned_sf,
    output logic [5:0]  o_entry_count,
    output logic [5:0]  o_load_sf7,
    output logic [5:0]  o_load_sf8,
    output logic [5:0]  o_load_sf9,
    output logic [5:0]  o_load_sf10,
    output logic [5:0]  o_load_sf11,
    output logic [5:0]  o_load_sf12,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W   = sftrk_pkg::IDX_W;
    localparam int CNT_W   = sftrk_pkg::CNT_W;
    localparam int SF_W    = sftrk_pkg::SF_W;
    localparam int ID_W    = sftrk_pkg::ID_W;
    localparam int ENTRY_W = sftrk_pkg::ENTRY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_SCAN,
        S_APPEND,
        S_REPORT
    } t_state;

    t_state                 r_state, n_state;
    logic [1:0]             r_mode, n_mode;
    logic [ID_W-1:0]        r_id, n_id;
    logic [SF_W-1:0]        r_sf, n_sf;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic [CNT_W-1:0]       r_rd, n_rd;
    logic [CNT_W-1:0]       r_wr, n_wr;
    logic                   r_pend, n_pend;
    sftrk_pkg::t_loads      r_load, n_load;
    logic                   r_ok, n_ok;
    logic [SF_W-1:0]        r_chosen, n_chosen;
    logic [3:0]             r_sf_min, n_sf_min;
    logic [3:0]             r_sf_max, n_sf_max;

    logic                   r_out_valid, n_out_valid;
    logic                   r_o_accepted, n_o_accepted;
    logic [3:0]             r_o_assigned, n_o_assigned;
    logic [CNT_W-1:0]       r_o_count, n_o_count;
    sftrk_pkg::t_loads      r_o_load, n_o_load;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic                   sel_start;
    sftrk_pkg::t_sel_stat   sel_stat;

    logic                   cfg_wr;
    logic [SF_W-1:0]        pick_sf;
    logic [SF_W-1:0]        rd_sf;
    logic [sftrk_pkg::SF_IDX_W-1:0] rd_k;
    logic [sftrk_pkg::SF_IDX_W-1:0] app_k;
    logic [6:0]             load_total;

    // entry ram: node id and factor per slot
    sftrk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (sftrk_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // least-loaded factor picker
    sftrk_minsel u_minsel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sel_start),
        .i_loads (r_load),
        .o_stat  (sel_stat)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = {28'd0, paddr[2] ? r_sf_max : r_sf_min};

    // factor decode helpers
    assign pick_sf = SF_W'(sftrk_pkg::SF_LOWEST) + SF_W'(sel_stat.best);
    assign rd_sf   = ram_rdata[SF_W-1:0];
    assign rd_k    = sftrk_pkg::SF_IDX_W'(rd_sf - SF_W'(sftrk_pkg::SF_LOWEST));
    assign app_k   = sftrk_pkg::SF_IDX_W'(r_sf - SF_W'(sftrk_pkg::SF_LOWEST));

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_id         = r_id;
        n_sf         = r_sf;
        n_fill       = r_fill;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_pend       = r_pend;
        n_load       = r_load;
        n_ok         = r_ok;
        n_chosen     = r_chosen;
        n_sf_min     = r_sf_min;
        n_sf_max     = r_sf_max;
        n_out_valid  = r_out_valid & i_out_stall;
        n_o_accepted = r_o_accepted;
        n_o_assigned = r_o_assigned;
        n_o_count    = r_o_count;
        n_o_load     = r_o_load;
        ram_we       = 1'b0;
        ram_waddr    = r_wr[IDX_W-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_rd[IDX_W-1:0];
        sel_start    = 1'b0;

        if (cfg_wr) begin
            if (paddr[2]) begin
                n_sf_max = pwdata[3:0];
            end else begin
                n_sf_min = pwdata[3:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_id     = i_node_id;
                    n_sf     = i_requested_sf[SF_W-1:0];
                    n_ok     = 1'b0;
                    n_chosen = '0;
                    n_rd     = '0;
                    n_wr     = '0;
                    n_pend   = 1'b0;
                    unique case (i_mode)
                        sftrk_pkg::MODE_REG: begin
                            if (sftrk_pkg::sf_ok(i_requested_sf, r_sf_min, r_sf_max)) begin
                                n_load  = '0;
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_REPORT;
                            end
                        end
                        sftrk_pkg::MODE_UNREG: begin
                            n_load  = '0;
                            n_state = S_SCAN;
                        end
                        sftrk_pkg::MODE_ASSIGN: begin
                            sel_start = 1'b1;
                            n_state   = S_PICK;
                        end
                        default: begin
                            n_state = S_REPORT;
                        end
                    endcase
                end
            end

            S_PICK: begin
                if (sel_stat.done) begin
                    if (sftrk_pkg::sf_ok({4'b0000, pick_sf}, r_sf_min, r_sf_max)) begin
                        n_sf    = pick_sf;
                        n_load  = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_REPORT;
                    end
                end
            end

            S_SCAN: begin
                // issue the next read while the previous entry is checked
                if (r_rd < r_fill) begin
                    ram_re = 1'b1;
                    n_rd   = r_rd + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                // keep entries of other nodes, compacted down
                if (r_pend && (ram_rdata[ENTRY_W-1:SF_W] != r_id)) begin
                    ram_we       = 1'b1;
                    n_wr         = r_wr + 1'b1;
                    n_load[rd_k] = r_load[rd_k] + 1'b1;
                end
                if ((r_rd == r_fill) && !r_pend) begin
                    n_state = S_APPEND;
                end
            end

            S_APPEND: begin
                if (r_mode == sftrk_pkg::MODE_UNREG) begin
                    n_fill = r_wr;
                    n_ok   = 1'b1;
                end else if (r_wr < CNT_W'(sftrk_pkg::DEPTH)) begin
                    ram_we        = 1'b1;
                    ram_wdata     = {r_id, r_sf};
                    n_fill        = r_wr + 1'b1;
                    n_load[app_k] = r_load[app_k] + 1'b1;
                    n_ok          = 1'b1;
                    n_chosen      = (r_mode == sftrk_pkg::MODE_ASSIGN) ? r_sf : '0;
                end else begin
                    // table full: old entries stay removed
                    n_fill = r_wr;
                end
                n_state = S_REPORT;
            end

            S_REPORT: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid  = 1'b1;
                    n_o_accepted = r_ok;
                    n_o_assigned = r_chosen;
                    n_o_count    = r_fill;
                    n_o_load     = r_load;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_load      <= '0;
            r_pend      <= 1'b0;
            r_sf_min    <= 4'd7;
            r_sf_max    <= 4'd12;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_load      <= n_load;
            r_pend      <= n_pend;
            r_sf_min    <= n_sf_min;
            r_sf_max    <= n_sf_max;
            r_out_valid <= n_out_valid;
        end
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_sf         <= n_sf;
        r_rd         <= n_rd;
        r_wr         <= n_wr;
        r_ok         <= n_ok;
        r_chosen     <= n_chosen;
        r_o_accepted <= n_o_accepted;
        r_o_assigned <= n_o_assigned;
        r_o_count    <= n_o_count;
        r_o_load     <= n_o_load;
    end

    // port drive
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_o_accepted;
    assign o_assigned_sf = r_o_assigned;
    assign o_entry_count = 6'(r_o_count);
    assign o_load_sf7    = 6'(r_o_load[0]);
    assign o_load_sf8    = 6'(r_o_load[1]);
    assign o_load_sf9    = 6'(r_o_load[2]);
    assign o_load_sf10   = 6'(r_o_load[3]);
    assign o_load_sf11   = 6'(r_o_load[4]);
    assign o_load_sf12   = 6'(r_o_load[5]);

    // sum of the per-factor loads
    assign load_total = 7'(r_load[0]) + 7'(r_load[1]) + 7'(r_load[2]) +
                        7'(r_load[3]) + 7'(r_load[4]) + 7'(r_load[5]);

    // checks
    `SFTRK_CHECK(a_fill_bound, r_fill <= CNT_W'(sftrk_pkg::DEPTH), "fill above table depth")
    `SFTRK_CHECK_IMP(a_load_sum, r_state == S_IDLE, load_total == 7'(r_fill), "loads disagree")
    `SFTRK_CHECK_IMP(a_compact_order, r_state == S_SCAN, r_wr <= r_rd, "write passed read")
    `SFTRK_CHECK_IMP(a_assign_ok, o_out_valid && |o_assigned_sf, o_accepted, "factor on a reject")

endmodule

// ===== design/sftrk_ram.sv =====
module sftrk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sftrk_minsel.sv =====
module sftrk_minsel (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sftrk_pkg::t_loads    i_loads,
    output sftrk_pkg::t_sel_stat o_stat
);

    localparam logic [sftrk_pkg::SF_IDX_W-1:0] LAST_IDX =
        sftrk_pkg::SF_IDX_W'(sftrk_pkg::SF_COUNT - 1);

    logic                                r_busy;
    logic                                r_done;
    logic [sftrk_pkg::SF_IDX_W-1:0]      r_idx;
    logic [sftrk_pkg::SF_IDX_W-1:0]      r_best;
    logic [sftrk_pkg::CNT_W-1:0]         r_min;
    logic [sftrk_pkg::CNT_W-1:0]         cur_load;

    // one compare per cycle against the running minimum
    assign cur_load = i_loads[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= sftrk_pkg::SF_IDX_W'(1);
                r_best <= '0;
                r_min  <= i_loads[0];
            end else if (r_busy) begin
                // strict less-than keeps the lowest factor on ties
                if (cur_load < r_min) begin
                    r_min  <= cur_load;
                    r_best <= r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.best = r_best;

endmodule

// ===== bench/least_loaded_sf_tracker_test.sv =====
module least_loaded_sf_tracker_test;

    // mode code with no operation behind it
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    // register byte addresses
    localparam logic [2:0] ADDR_SF_MIN = 3'd0;
    localparam logic [2:0] ADDR_SF_MAX = 3'd4;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         POOL_SIZE   = 40;
    localparam int         PHASE_OPS   = 66;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] node_id;
        logic [7:0]  req_sf;
    } t_op;

    typedef struct packed {
        logic              accepted;
        logic [3:0]        assigned_sf;
        logic [5:0]        entry_count;
        sftrk_pkg::t_loads loads;
    } t_outcome;

    // clock and reset
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    // item channel
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_mode = '0;
    logic [63:0] i_node_id = '0;
    logic [7:0]  i_requested_sf = '0;
    // result channel
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_accepted;
    logic [3:0]  o_assigned_sf;
    logic [5:0]  o_entry_count;
    logic [5:0]  o_load_sf7, o_load_sf8, o_load_sf9;
    logic [5:0]  o_load_sf10, o_load_sf11, o_load_sf12;
    // register port
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    least_loaded_sf_tracker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_node_id      (i_node_id),
        .i_requested_sf (i_requested_sf),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_assigned_sf  (o_assigned_sf),
        .o_entry_count  (o_entry_count),
        .o_load_sf7     (o_load_sf7),
        .o_load_sf8     (o_load_sf8),
        .o_load_sf9     (o_load_sf9),
        .o_load_sf10    (o_load_sf10),
        .o_load_sf11    (o_load_sf11),
        .o_load_sf12    (o_load_sf12),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the node table and the factor window
    logic [63:0] tbl_id [sftrk_pkg::DEPTH];
    logic [3:0]  tbl_sf [sftrk_pkg::DEPTH];
    int          tbl_fill = 0;
    logic [3:0]  cfg_sf_min = 4'd7;
    logic [3:0]  cfg_sf_max = 4'd12;

    t_op         op_q [$];
    t_outcome    outcome_q [$];
    t_op         cur_op;
    logic [63:0] id_pool [POOL_SIZE];
    bit          idling_on = 1'b1;
    int          send_gap = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          errors = 0;
    int          ops_taken = 0;
    int          results_seen = 0;
    int          grants = 0;
    int          assign_grants = 0;
    int          full_refusals = 0;

    function automatic bit factor_allowed(input logic [7:0] sf);
        return sf >= 8'(sftrk_pkg::SF_LOWEST) &&
               sf < 8'(sftrk_pkg::SF_LOWEST + sftrk_pkg::SF_COUNT) &&
               sf >= {4'b0000, cfg_sf_min} && sf <= {4'b0000, cfg_sf_max};
    endfunction

    // remove every entry of the node, keeping the rest packed at the bottom
    function automatic void purge_node(input logic [63:0] id);
        int keep;
        keep = 0;
        for (int r = 0; r < tbl_fill; r++) begin
            if (tbl_id[r] != id) begin
                tbl_id[keep] = tbl_id[r];
                tbl_sf[keep] = tbl_sf[r];
                keep++;
            end
        end
        tbl_fill = keep;
    endfunction

    // bad factor leaves the table alone; full table keeps the node removed
    function automatic bit enroll_node(input logic [63:0] id, input logic [7:0] sf);
        if (!factor_allowed(sf))
            return 1'b0;
        purge_node(id);
        if (tbl_fill >= sftrk_pkg::DEPTH) begin
            full_refusals++;
            return 1'b0;
        end
        tbl_id[tbl_fill] = id;
        tbl_sf[tbl_fill] = sf[3:0];
        tbl_fill++;
        return 1'b1;
    endfunction

    function automatic sftrk_pkg::t_loads tally_loads();
        sftrk_pkg::t_loads ld;
        ld = '0;
        for (int i = 0; i < tbl_fill; i++)
            ld[tbl_sf[i] - sftrk_pkg::SF_LOWEST] =
                ld[tbl_sf[i] - sftrk_pkg::SF_LOWEST] + 1'b1;
        return ld;
    endfunction

    function automatic t_outcome predict_outcome(input t_op op);
        t_outcome          res;
        sftrk_pkg::t_loads ld;
        int                best;
        res = '0;
        case (op.mode)
            sftrk_pkg::MODE_REG: begin
                res.accepted = enroll_node(op.node_id, op.req_sf);
            end
            sftrk_pkg::MODE_UNREG: begin
                purge_node(op.node_id);
                res.accepted = 1'b1;
            end
            sftrk_pkg::MODE_ASSIGN: begin
                // least-loaded factor, lowest wins a tie
                ld = tally_loads();
                best = 0;
                for (int i = 1; i < sftrk_pkg::SF_COUNT; i++)
                    if (ld[i] < ld[best])
                        best = i;
                if (enroll_node(op.node_id, 8'(sftrk_pkg::SF_LOWEST + best))) begin
                    res.accepted = 1'b1;
                    res.assigned_sf = 4'(sftrk_pkg::SF_LOWEST + best);
                end
            end
            default: ;
        endcase
        res.entry_count = 6'(tbl_fill);
        res.loads = tally_loads();
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        errors++;
    endtask

    // item driver: predicts each beat as it is taken
    always @(posedge i_clk) begin : driver
        t_op nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                outcome_q.push_back(predict_outcome(cur_op));
                ops_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 16);
                    i_in_valid <= 1'b0;
                end else if (op_q.size() != 0) begin
                    nxt = op_q.pop_front();
                    cur_op = nxt;
                    i_mode <= nxt.mode;
                    i_node_id <= nxt.node_id;
                    i_requested_sf <= nxt.req_sf;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall bursts
    always @(posedge i_clk) begin : monitor
        t_outcome          want;
        sftrk_pkg::t_loads seen;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen = {o_load_sf12, o_load_sf11, o_load_sf10,
                        o_load_sf9, o_load_sf8, o_load_sf7};
                if (outcome_q.size() == 0) begin
                    flag_mismatch($sformatf("result %0d with nothing outstanding",
                                            results_seen), 1, 0);
                end else begin
                    want = outcome_q.pop_front();
                    if (o_accepted !== want.accepted)
                        flag_mismatch($sformatf("result %0d accepted", results_seen),
                                      o_accepted, want.accepted);
                    if (o_assigned_sf !== want.assigned_sf)
                        flag_mismatch($sformatf("result %0d assigned_sf", results_seen),
                                      o_assigned_sf, want.assigned_sf);
                    if (o_entry_count !== want.entry_count)
                        flag_mismatch($sformatf("result %0d entry_count", results_seen),
                                      o_entry_count, want.entry_count);
                    for (int i = 0; i < sftrk_pkg::SF_COUNT; i++)
                        if (seen[i] !== want.loads[i])
                            flag_mismatch($sformatf("result %0d load_sf%0d", results_seen,
                                                    sftrk_pkg::SF_LOWEST + i),
                                          seen[i], want.loads[i]);
                    if (want.accepted)
                        grants++;
                    if (want.assigned_sf != 0)
                        assign_grants++;
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 16);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // no beat on either channel for too long means the block hung
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_op make_op(input logic [1:0] mode, input logic [63:0] id,
                                    input logic [7:0] sf);
        t_op op;
        op.mode = mode;
        op.node_id = id;
        op.req_sf = sf;
        return op;
    endfunction

    // mostly valid factors on a small node pool so the table fills up
    function automatic t_op random_op();
        t_op op;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op.mode = sftrk_pkg::MODE_REG;
        else if (pick < 60)
            op.mode = sftrk_pkg::MODE_UNREG;
        else if (pick < 95)
            op.mode = sftrk_pkg::MODE_ASSIGN;
        else
            op.mode = MODE_SPARE;
        if ($urandom_range(0, 99) < 88) begin
            op.node_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            op.node_id = {$urandom, $urandom};
            id_pool[$urandom_range(2, POOL_SIZE - 1)] = op.node_id;
        end
        pick = $urandom_range(0, 9);
        if (pick < 8)
            op.req_sf = 8'($urandom_range(7, 12));
        else if (pick == 8)
            op.req_sf = 8'($urandom_range(0, 15));
        else
            op.req_sf = 8'($urandom_range(0, 255));
        return op;
    endfunction

    task automatic drain();
        do
            @(posedge i_clk);
        while (op_q.size() != 0 || i_in_valid || outcome_q.size() != 0);
    endtask

    // setup and access beat, then read the register back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_SF_MIN)
            cfg_sf_min = data[3:0];
        else
            cfg_sf_max = data[3:0];
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[3:0] !== data[3:0])
            flag_mismatch($sformatf("readback of register at %0d", addr),
                          prdata, data[3:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // new factor window, then random ops with a full pause half way
    task automatic run_phase(input logic [31:0] min_word, input logic [31:0] max_word);
        drain();
        repeat (4) @(posedge i_clk);
        write_reg(ADDR_SF_MIN, min_word);
        write_reg(ADDR_SF_MAX, max_word);
        for (int n = 0; n < PHASE_OPS / 2; n++)
            op_q.push_back(random_op());
        drain();
        for (int n = PHASE_OPS / 2; n < PHASE_OPS; n++)
            op_q.push_back(random_op());
    endtask

    initial begin : stimulus
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = {$urandom, $urandom};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: field extremes, each mode, rejects and replacement
        write_reg(ADDR_SF_MIN, 32'd7);
        write_reg(ADDR_SF_MAX, 32'd12);
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    64'h0, 8'd7));
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    '1, 8'd12));
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    64'h0, 8'd9));
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    64'h5555_aaaa_5555_aaaa, 8'd6));
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    64'h5555_aaaa_5555_aaaa, 8'd13));
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    64'h5555_aaaa_5555_aaaa, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    64'h5555_aaaa_5555_aaaa, 8'd255));
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    64'h5555_aaaa_5555_aaaa, 8'd8));
        op_q.push_back(make_op(sftrk_pkg::MODE_UNREG,  64'haaaa_5555_aaaa_5555, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_UNREG,  64'h5555_aaaa_5555_aaaa, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_ASSIGN, 64'haaaa_5555_aaaa_5555, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_ASSIGN, 64'h8000_0000_0000_0001, 8'd255));
        op_q.push_back(make_op(sftrk_pkg::MODE_ASSIGN, 64'haaaa_5555_aaaa_5555, 8'd0));
        op_q.push_back(make_op(MODE_SPARE,             64'h0, 8'd10));
        op_q.push_back(make_op(MODE_SPARE,             '1, 8'd7));
        op_q.push_back(make_op(sftrk_pkg::MODE_ASSIGN, 64'h0000_0001_0000_0000, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_ASSIGN, 64'h0000_0000_ffff_ffff, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_ASSIGN, 64'hffff_ffff_0000_0000, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_ASSIGN, 64'h7fff_ffff_ffff_fffe, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_ASSIGN, 64'h0, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_UNREG,  '1, 8'd0));
        op_q.push_back(make_op(sftrk_pkg::MODE_REG,    64'h0, 8'd11));

        // full window, narrow, empty, single factors, masked writes, 4-bit extremes
        run_phase(32'd7, 32'd12);
        run_phase(32'd9, 32'd10);
        run_phase(32'd12, 32'd7);
        run_phase(32'd7, 32'd7);
        run_phase(32'd12, 32'd12);
        run_phase(32'hffff_fff8, 32'ha5a5_a5ab);
        run_phase(32'hffff_fff0, 32'h0000_000f);
        drain();
        idling_on = 1'b0;
        run_phase(32'd7, 32'd12);

        drain();
        repeat (60) @(posedge i_clk);
        $display("covered %0d ops and %0d results: %0d granted, %0d by assign,",
                 ops_taken, results_seen, grants, assign_grants);
        $display("%0d refused on a full table; eight factor windows incl. empty and masked",
                 full_refusals);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/sftrk_pkg.sv
design/sftrk_ram.sv
design/sftrk_minsel.sv
design/least_loaded_sf_tracker.sv
bench/least_loaded_sf_tracker_test.sv
